>>> rtl/tna_pkg.sv
// Shared constants for the triangle normal and area block.
package tna_pkg;

  localparam int COORD_W    = 16;  // input coordinate field width
  localparam int NUM_COORDS = 9;   // three vertices, three axes each
  localparam int COMP_W     = 16;  // unit normal component width
  localparam int AREA_W     = 35;  // face area width
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 88;

endpackage

>>> rtl/tna_front.sv
// Edge vectors, cross product, squared components and squared length.
module tna_front #(
  parameter int CB = 16
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  en,
  input  logic                                                  in_valid,
  input  logic [tna_pkg::NUM_COORDS-1:0][tna_pkg::COORD_W-1:0]  coord,
  output logic                                                  out_valid,
  output logic [2:0][2*(2*CB+1)-1:0]                            a2,
  output logic [2*(2*CB+1)+1:0]                                 s,
  output logic [2:0]                                            neg,
  output logic                                                  degen
);

  localparam int AW = 2*CB + 1;  // magnitude of a cross component
  localparam int PW = 2*CB + 2;  // signed edge product
  localparam int NW = 2*AW;      // squared component
  localparam int SW = NW + 2;    // sum of three squares

  logic [4:0]                v_r;
  logic signed [CB:0]        u_r [3];
  logic signed [CB:0]        w_r [3];
  logic signed [PW-1:0]      p_r [6];
  logic [AW-1:0]             a_r [3];
  logic [2:0]                neg3_r, neg4_r, neg5_r;
  logic [NW-1:0]             sq_r [3];
  logic [2:0][NW-1:0]        a2_r;
  logic [SW-1:0]             s_r;
  logic                      degen_r;

  logic signed [CB:0]        u_nxt [3];
  logic signed [CB:0]        w_nxt [3];
  logic signed [PW:0]        n_c [3];
  logic [AW-1:0]             a_nxt [3];
  logic [2:0]                neg_nxt;
  logic [SW-1:0]             s_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_nxt[i] = $signed({1'b0, coord[3+i][CB-1:0]}) - $signed({1'b0, coord[i][CB-1:0]});
      w_nxt[i] = $signed({1'b0, coord[6+i][CB-1:0]}) - $signed({1'b0, coord[i][CB-1:0]});
    end
  end

  always_comb begin
    n_c[0] = p_r[0] - p_r[1];
    n_c[1] = p_r[2] - p_r[3];
    n_c[2] = p_r[4] - p_r[5];
    for (int i = 0; i < 3; i++) begin
      neg_nxt[i] = n_c[i][PW];
      a_nxt[i]   = neg_nxt[i] ? AW'(-n_c[i]) : AW'(n_c[i]);
    end
  end

  assign s_nxt = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i]  <= u_nxt[i];
        w_r[i]  <= w_nxt[i];
        a_r[i]  <= a_nxt[i];
        sq_r[i] <= a_r[i] * a_r[i];
        a2_r[i] <= sq_r[i];
      end
      p_r[0]  <= u_r[1] * w_r[2];
      p_r[1]  <= u_r[2] * w_r[1];
      p_r[2]  <= u_r[2] * w_r[0];
      p_r[3]  <= u_r[0] * w_r[2];
      p_r[4]  <= u_r[0] * w_r[1];
      p_r[5]  <= u_r[1] * w_r[0];
      neg3_r  <= neg_nxt;
      neg4_r  <= neg3_r;
      neg5_r  <= neg4_r;
      s_r     <= s_nxt;
      degen_r <= (s_nxt == '0);
    end
  end

  assign out_valid = v_r[4];
  assign a2        = a2_r;
  assign s         = s_r;
  assign neg       = neg5_r;
  assign degen     = degen_r;

endmodule

>>> rtl/tna_div.sv
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
module tna_div #(
  parameter int LANES = 3,
  parameter int NW    = 66,
  parameter int DW    = 68,
  parameter int QB    = 31,
  parameter int TAG_W = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NW-1:0]    num,
  input  logic [DW-1:0]               den,
  input  logic [TAG_W-1:0]            in_tag,
  output logic                        out_valid,
  output logic [LANES-1:0][QB-1:0]    quo,
  output logic [TAG_W-1:0]            out_tag
);

  logic                v_r   [QB];
  logic [DW-1:0]       d_r   [QB];
  logic [TAG_W-1:0]    tag_r [QB];
  logic [DW-1:0]       rem_r [QB][LANES];
  logic [QB-1:0]       q_r   [QB][LANES];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic                v_prev;
    logic [DW-1:0]       d_prev;
    logic [TAG_W-1:0]    tag_prev;
    logic [DW:0]         r_c    [LANES];
    logic [QB-1:0]       q_prev [LANES];
    logic                ge     [LANES];
    logic [DW-1:0]       rem_nxt [LANES];
    logic [QB-1:0]       q_nxt   [LANES];

    if (j == 0) begin : g_first
      always_comb begin
        v_prev   = in_valid;
        d_prev   = den;
        tag_prev = in_tag;
        for (int l = 0; l < LANES; l++) begin
          r_c[l]    = (DW+1)'(num[l]);
          q_prev[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        v_prev   = v_r[j-1];
        d_prev   = d_r[j-1];
        tag_prev = tag_r[j-1];
        for (int l = 0; l < LANES; l++) begin
          r_c[l]    = {rem_r[j-1][l], 1'b0};
          q_prev[l] = q_r[j-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        ge[l]      = (r_c[l] >= {1'b0, d_prev});
        rem_nxt[l] = ge[l] ? DW'(r_c[l] - {1'b0, d_prev}) : DW'(r_c[l]);
        q_nxt[l]   = {q_prev[l][QB-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[j]   <= d_prev;
        tag_r[j] <= tag_prev;
        for (int l = 0; l < LANES; l++) begin
          rem_r[j][l] <= rem_nxt[l];
          q_r[j][l]   <= q_nxt[l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l] = q_r[QB-1][l];
    end
  end

  assign out_valid = v_r[QB-1];
  assign out_tag   = tag_r[QB-1];

endmodule

>>> rtl/tna_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module tna_sqrt #(
  parameter int LANES = 1,
  parameter int IW    = 70,
  parameter int TAG_W = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [LANES-1:0][IW-1:0]      x,
  input  logic [TAG_W-1:0]              in_tag,
  output logic                          out_valid,
  output logic [LANES-1:0][IW/2-1:0]    root,
  output logic [TAG_W-1:0]              out_tag
);

  localparam int RW = IW / 2;

  logic                v_r    [RW];
  logic [TAG_W-1:0]    tag_r  [RW];
  logic [IW-1:0]       x_r    [RW][LANES];
  logic [RW:0]         rem_r  [RW][LANES];
  logic [RW-1:0]       root_r [RW][LANES];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic                v_prev;
    logic [TAG_W-1:0]    tag_prev;
    logic [IW-1:0]       x_prev    [LANES];
    logic [RW:0]         rem_prev  [LANES];
    logic [RW-1:0]       root_prev [LANES];
    logic [RW+2:0]       remsh     [LANES];
    logic [RW+2:0]       trial     [LANES];
    logic                ge        [LANES];
    logic [RW:0]         rem_nxt   [LANES];
    logic [RW-1:0]       root_nxt  [LANES];

    if (j == 0) begin : g_first
      always_comb begin
        v_prev   = in_valid;
        tag_prev = in_tag;
        for (int l = 0; l < LANES; l++) begin
          x_prev[l]    = x[l];
          rem_prev[l]  = '0;
          root_prev[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        v_prev   = v_r[j-1];
        tag_prev = tag_r[j-1];
        for (int l = 0; l < LANES; l++) begin
          x_prev[l]    = x_r[j-1][l];
          rem_prev[l]  = rem_r[j-1][l];
          root_prev[l] = root_r[j-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        remsh[l]    = {rem_prev[l], x_prev[l][IW-1:IW-2]};
        trial[l]    = (RW+3)'({root_prev[l], 2'b01});
        ge[l]       = (remsh[l] >= trial[l]);
        rem_nxt[l]  = ge[l] ? (RW+1)'(remsh[l] - trial[l]) : (RW+1)'(remsh[l]);
        root_nxt[l] = {root_prev[l][RW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[j] <= tag_prev;
        for (int l = 0; l < LANES; l++) begin
          x_r[j][l]    <= {x_prev[l][IW-3:0], 2'b00};
          rem_r[j][l]  <= rem_nxt[l];
          root_r[j][l] <= root_nxt[l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      root[l] = root_r[RW-1][l];
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_tag   = tag_r[RW-1];

endmodule

>>> rtl/triangle_normal_and_area.sv
// Top level: triangle face unit normal and area, one triangle per cycle when not stalled.
//
//  channel | ports                       | contents
//  --------+-----------------------------+------------------------------------------
//  input   | in_tvalid/in_tready/in_tdata| nine vertex coordinates
//  output  | out_tvalid/out_tready/      | unit normal (x,y,z), area; tuser: degenerate
//          | out_tdata/out_tuser         |
//
// A triangle is taken every cycle unless a result waits on out_tready.
// The bit-per-stage area square root, normal divider and normal square root run in series.
// Reset clears every stage valid bit and the output valid bit.
// The whole pipeline holds while a result waits on out_tready.
module triangle_normal_and_area #(
  parameter int COORD_BITS       = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
  input  logic [tna_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // unit_nx, unit_ny, unit_nz, face_area, zero fill
  output logic [tna_pkg::OUT_DATA_W-1:0]   out_tdata,
  // degenerate
  output logic [0:0]                       out_tuser
);

  localparam int CB    = COORD_BITS;
  localparam int F     = NORMAL_FRAC_BITS;
  localparam int AW    = 2*CB + 1;
  localparam int NW    = 2*AW;
  localparam int SW    = NW + 2;
  localparam int ARW   = SW/2 + 1;       // area root width
  localparam int QB    = 2*F + 3;        // quotient bits
  localparam int NRW   = F + 2;          // normal root width
  localparam int TAG1  = 3*NW + SW + 4;
  localparam int TAG2  = ARW + 4;

  logic en;

  logic                                            fr_valid;
  logic [2:0][NW-1:0]                              fr_a2;
  logic [SW-1:0]                                   fr_s;
  logic [2:0]                                      fr_neg;
  logic                                            fr_degen;

  logic                                            ar_valid;
  logic [0:0][ARW-1:0]                             ar_root;
  logic [TAG1-1:0]                                 ar_tag;
  logic [0:0][SW+1:0]                              ar_x;

  logic                                            dv_valid;
  logic [2:0][QB-1:0]                              dv_quo;
  logic [TAG2-1:0]                                 dv_tag;
  logic [2:0][NW-1:0]                              dv_num;
  logic [SW-1:0]                                   dv_den;
  logic [2:0][2*NRW-1:0]                           ns_x;

  logic                                            ns_valid;
  logic [2:0][NRW-1:0]                             ns_root;
  logic [TAG2-1:0]                                 ns_tag;

  logic [2:0]                                      fin_neg;
  logic                                            fin_degen;
  logic [ARW-1:0]                                  fin_area;
  logic [tna_pkg::COMP_W-1:0]                      comp_nxt [3];

  logic                                            out_tvalid_r;
  logic [tna_pkg::COMP_W-1:0]                      comp_r [3];
  logic [tna_pkg::AREA_W-1:0]                      area_r;
  logic                                            degen_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  tna_front #(.CB(CB)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .coord     (in_tdata),
    .out_valid (fr_valid),
    .a2        (fr_a2),
    .s         (fr_s),
    .neg       (fr_neg),
    .degen     (fr_degen)
  );

  // sqrt(4*S) gives four times the area
  assign ar_x[0] = {fr_s, 2'b00};

  tna_sqrt #(.LANES(1), .IW(SW+2), .TAG_W(TAG1)) u_area_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .x         (ar_x),
    .in_tag    ({fr_a2, fr_s, fr_neg, fr_degen}),
    .out_valid (ar_valid),
    .root      (ar_root),
    .out_tag   (ar_tag)
  );

  assign {dv_num, dv_den} = ar_tag[TAG1-1:4];

  // floor(a^2 * 2^(2F+2) / S)
  tna_div #(.LANES(3), .NW(NW), .DW(SW), .QB(QB), .TAG_W(TAG2)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ar_valid),
    .num       (dv_num),
    .den       (dv_den),
    .in_tag    ({ar_root[0], ar_tag[3:0]}),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .out_tag   (dv_tag)
  );

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ns_x[l] = (2*NRW)'(dv_quo[l]);
    end
  end

  tna_sqrt #(.LANES(3), .IW(2*NRW), .TAG_W(TAG2)) u_norm_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_valid),
    .x         (ns_x),
    .in_tag    (dv_tag),
    .out_valid (ns_valid),
    .root      (ns_root),
    .out_tag   (ns_tag)
  );

  assign fin_area  = ns_tag[TAG2-1:4];
  assign fin_neg   = ns_tag[3:1];
  assign fin_degen = ns_tag[0];

  // round half up: (root + 1) / 2, then apply the sign
  always_comb begin
    logic [NRW-1:0] mag;
    logic [31:0]    sgn;
    for (int l = 0; l < 3; l++) begin
      mag = NRW'(ns_root[l] + NRW'(1)) >> 1;
      sgn = fin_neg[l] ? (32'd0 - 32'(mag)) : 32'(mag);
      comp_nxt[l] = fin_degen ? '0 : sgn[tna_pkg::COMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= ns_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        comp_r[l] <= comp_nxt[l];
      end
      area_r  <= tna_pkg::AREA_W'(fin_area);
      degen_r <= fin_degen;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = {5'b0, area_r, comp_r[2], comp_r[1], comp_r[0]};
  assign out_tuser[0] = degen_r;

endmodule
